[src/node_level_mismatch_flagger_assert.svh]
// Assertion macros for the node level mismatch flagger.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef NODE_LEVEL_MISMATCH_FLAGGER_ASSERT_SVH
`define NODE_LEVEL_MISMATCH_FLAGGER_ASSERT_SVH

`ifndef SYNTH
`define NLMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NLMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NLMF_ASSERT(lbl, prop, msg)
`define NLMF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[src/nlmf_pkg.sv]
// Shared types and constants for the node level mismatch flagger.
// No dependencies.
`default_nettype none

package nlmf_pkg;

  localparam int unsigned NodeCount     = 4096;
  localparam int unsigned AddrW         = $clog2(NodeCount);
  localparam int unsigned NodeIdxW      = 12;
  localparam int unsigned LevelW        = 8;
  localparam logic [LevelW-1:0] LevelMax      = 8'hFF;
  localparam logic [LevelW-1:0] MismatchReset = 8'd1;

  typedef enum logic [1:0] {
    KindClear  = 2'd0,
    KindRecord = 2'd1,
    KindCheck  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [NodeIdxW-1:0] node_index;
    logic [LevelW-1:0]   level;
    logic                elem_refine;
    logic                last_node;
  } in_beat_t;

  typedef struct packed {
    logic refine_mark;
    logic newly_marked;
    logic any_changed;
  } out_beat_t;

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [LevelW-1:0] wdata;
  } ram_wr_t;

endpackage

`default_nettype wire

[src/nlmf_level_ram.sv]
// Node level table: one write port, one registered read port (old data on collision).
// Depends on nlmf_pkg.
`default_nettype none

module nlmf_level_ram (
  input  wire logic                         clk_i,
  input  wire logic                         rd_en_i,
  input  wire logic [nlmf_pkg::AddrW-1:0]   rd_addr_i,
  output logic      [nlmf_pkg::LevelW-1:0]  rd_data_o,
  input  wire nlmf_pkg::ram_wr_t            wr_i
);

  logic [nlmf_pkg::LevelW-1:0] mem [nlmf_pkg::NodeCount];
  logic [nlmf_pkg::LevelW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.waddr] <= wr_i.wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[src/node_level_mismatch_flagger.sv]
// Top level of the node level mismatch flagger: node table control and result register.
// Depends on nlmf_pkg, nlmf_level_ram and node_level_mismatch_flagger_assert.svh.
`default_nettype none
`include "node_level_mismatch_flagger_assert.svh"

// After reset the block sweeps the 4096-entry node table to zero, one entry per cycle,
// and holds in_ready_o low until the sweep ends. From then on it takes one node beat
// per cycle: the table read is issued when a beat is accepted, the compare or update and
// the write-back happen when the beat leaves stage 1; a write made there is forwarded
// to the beat that follows it. A check beat closing an element loads the output
// register; if that register is still full and not taken, input stalls until it is.
module node_level_mismatch_flagger (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [nlmf_pkg::LevelW-1:0]  cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire nlmf_pkg::in_beat_t           in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output nlmf_pkg::out_beat_t               out_data_o
);

  localparam logic [nlmf_pkg::AddrW-1:0] LastAddr = nlmf_pkg::AddrW'(nlmf_pkg::NodeCount - 1);

  logic [nlmf_pkg::LevelW-1:0] mm_q;
  logic                        clr_busy_q;
  logic [nlmf_pkg::AddrW-1:0]  clr_addr_q;
  logic                        s1_vld_q;
  nlmf_pkg::in_beat_t          s1_beat_q;
  logic                        fwd_vld_q;
  logic [nlmf_pkg::AddrW-1:0]  fwd_addr_q;
  logic [nlmf_pkg::LevelW-1:0] fwd_data_q;
  logic                        viol_q, viol_d;
  logic                        run_q, run_d;
  logic                        out_vld_q, out_vld_d;
  nlmf_pkg::out_beat_t         out_q, res;

  logic                        in_acc, s1_res, s1_go, s1_fire, hit, newly;
  logic [nlmf_pkg::AddrW-1:0]  s1_addr;
  logic [nlmf_pkg::LevelW-1:0] rd_data, cur;
  logic [nlmf_pkg::LevelW:0]   eff_raw, lim;
  logic [nlmf_pkg::LevelW-1:0] eff;
  nlmf_pkg::ram_wr_t           s1_wr, ram_wr;

  assign s1_addr = s1_beat_q.node_index[nlmf_pkg::AddrW-1:0];
  assign s1_res  = s1_vld_q && (s1_beat_q.kind == nlmf_pkg::KindCheck) && s1_beat_q.last_node;
  assign s1_go   = !s1_res || !out_vld_q || out_ready_i;
  assign s1_fire = s1_vld_q && s1_go;
  assign in_ready_o = !clr_busy_q && (!s1_vld_q || s1_go);
  assign in_acc  = in_valid_i && in_ready_o;

  nlmf_level_ram u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (in_data_i.node_index[nlmf_pkg::AddrW-1:0]),
    .rd_data_o (rd_data),
    .wr_i      (ram_wr)
  );

  assign cur     = (fwd_vld_q && (fwd_addr_q == s1_addr)) ? fwd_data_q : rd_data;
  assign eff_raw = {1'b0, s1_beat_q.level} + {{nlmf_pkg::LevelW{1'b0}},
                   s1_beat_q.elem_refine};
  assign eff     = eff_raw[nlmf_pkg::LevelW] ? nlmf_pkg::LevelMax
                                             : eff_raw[nlmf_pkg::LevelW-1:0];
  assign lim     = {1'b0, s1_beat_q.level} + {1'b0, mm_q};
  assign hit     = !s1_beat_q.elem_refine && (lim < {1'b0, cur});

  always_comb begin
    s1_wr.we    = 1'b0;
    s1_wr.waddr = s1_addr;
    s1_wr.wdata = '0;
    viol_d      = viol_q;
    run_d       = run_q;
    newly       = 1'b0;
    if (s1_fire) begin
      unique case (s1_beat_q.kind)
        nlmf_pkg::KindClear: begin
          s1_wr.we = 1'b1;
          run_d    = 1'b0;
        end
        nlmf_pkg::KindRecord: begin
          s1_wr.we    = eff > cur;
          s1_wr.wdata = eff;
        end
        nlmf_pkg::KindCheck: begin
          viol_d = viol_q || hit;
          if (s1_beat_q.last_node) begin
            newly  = !s1_beat_q.elem_refine && viol_d;
            run_d  = run_q || newly;
            viol_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res.refine_mark  = s1_beat_q.elem_refine || newly;
  assign res.newly_marked = newly;
  assign res.any_changed  = run_d;

  always_comb begin
    if (clr_busy_q) begin
      ram_wr.we    = 1'b1;
      ram_wr.waddr = clr_addr_q;
      ram_wr.wdata = '0;
    end else begin
      ram_wr = s1_wr;
    end
  end

  assign out_vld_d = (s1_fire && s1_res) || (out_vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_q       <= nlmf_pkg::MismatchReset;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      s1_vld_q   <= 1'b0;
      fwd_vld_q  <= 1'b0;
      viol_q     <= 1'b0;
      run_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mm_q <= cfg_wdata_i;
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == LastAddr) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_acc) begin
        s1_vld_q  <= 1'b1;
        fwd_vld_q <= s1_wr.we;
      end else if (s1_fire) begin
        s1_vld_q <= 1'b0;
      end
      viol_q    <= viol_d;
      run_q     <= run_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_beat_q  <= in_data_i;
      fwd_addr_q <= s1_wr.waddr;
      fwd_data_q <= s1_wr.wdata;
    end
    if (s1_fire && s1_res) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `NLMF_ASSERT(a_no_accept_in_sweep, clr_busy_q |-> !in_ready_o, "beat taken during sweep")
  `NLMF_ASSERT(a_newly_mark, out_vld_q && out_q.newly_marked |-> out_q.refine_mark, "bad mark")
  `NLMF_ASSERT(a_newly_run, out_vld_q && out_q.newly_marked |-> out_q.any_changed, "bad run")
  `NLMF_ASSERT_NEXT(a_viol_cleared, s1_fire && s1_res, !viol_q, "violation kept past end")
  `NLMF_ASSERT_NEXT(a_sweep_ends, clr_busy_q && (clr_addr_q == LastAddr), !clr_busy_q, "overrun")

endmodule

`default_nettype wire
